// File: rtl/bsc_pkg.sv
// package for the barometric sensor compensation unit
// types, constants and helper functions shared by all rtl modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CAL_A = 2'd0,
        REG_CAL_B = 2'd1,
        REG_CAL_C = 2'd2,
        REG_OSS   = 2'd3
    } cfg_idx_t;

    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned TEMP_STAGES = 2;
    localparam int unsigned PRES_STAGES = 8;
    localparam int unsigned POST_STAGES = 4;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] X3_BIAS    = 32'd32768;
    localparam logic [31:0] PRES_SCALE = 32'd50000;
    localparam logic [31:0] SQ_COEF    = 32'd3038;
    localparam logic [31:0] LIN_COEF   = 32'hFFFF_E343;   // -7357
    localparam logic [31:0] PRES_BIAS  = 32'd3791;
    localparam logic [31:0] TEMP_ROUND = 32'd8;
    localparam logic [31:0] B3_ROUND   = 32'd2;
    localparam logic [31:0] PRES_MAX   = 32'd262143;

    // calibration coefficients, widened to 32 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } cal_t;

    // payload carried down the whole pipe; the work words change meaning per stage
    typedef struct packed {
        logic        err;
        logic        fl;
        logic [15:0] temp;
        logic [18:0] up;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } pl_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [15:0] sat_temp(input logic [31:0] t);
        logic [15:0] r;
        if ($signed(t) < -32'sd32768)
            r = 16'h8000;
        else if ($signed(t) > 32'sd32767)
            r = 16'h7FFF;
        else
            r = t[15:0];
        return r;
    endfunction

    function automatic logic [17:0] sat_pres(input logic [31:0] p);
        logic [17:0] r;
        if (p[31])
            r = '0;
        else if (p > PRES_MAX)
            r = PRES_MAX[17:0];
        else
            r = p[17:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bsc_sample_if.sv
// item channel for raw sensor readings
// valid/ready handshake with the raw temperature and pressure words; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bsc_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

`default_nettype wire

// File: rtl/bsc_result_if.sv
// item channel for compensated results
// valid/ready handshake with temperature, pressure and error flag; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bsc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               divide_error;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output divide_error, input ready);
    modport sink (input valid, input temperature_tenths, input pressure_pa,
                  input divide_error, output ready);
endinterface

`default_nettype wire

// File: rtl/bsc_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// divides w0 by w1 of the payload, quotient back in w0; uses bsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsc_div
    import bsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire pl_t  in_pl,
    output logic      out_valid,
    input  wire logic out_ready,
    output pl_t       out_pl
);

    logic [DIV_STEPS-1:0] v_reg;
    logic [DIV_STEPS:0]   adv;
    pl_t                  pl_reg   [DIV_STEPS];
    pl_t                  pl_next  [DIV_STEPS];
    logic [31:0]          rem_reg  [DIV_STEPS];
    logic [31:0]          rem_next [DIV_STEPS];

    assign adv[DIV_STEPS] = out_ready;
    assign in_ready       = adv[0];
    assign out_valid      = v_reg[DIV_STEPS-1];
    assign out_pl         = pl_reg[DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic        src_v;
        pl_t         src_pl;
        logic [31:0] src_rem;
        logic [32:0] trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign src_v   = in_valid;
            assign src_pl  = in_pl;
            assign src_rem = '0;
        end
        else
        begin : g_rest
            assign src_v   = v_reg[k-1];
            assign src_pl  = pl_reg[k-1];
            assign src_rem = rem_reg[k-1];
        end

        assign adv[k] = !v_reg[k] || adv[k+1];
        assign trial  = {src_rem, src_pl.w0[31]};
        assign ge     = trial >= {1'b0, src_pl.w1};

        always_comb
        begin
            pl_next[k]    = src_pl;
            pl_next[k].w0 = {src_pl.w0[30:0], ge};
            rem_next[k]   = ge ? 32'(trial - {1'b0, src_pl.w1}) : trial[31:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv[k])
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_v)
            begin
                pl_reg[k]  <= pl_next[k];
                rem_reg[k] <= rem_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/bsc_temp.sv
// temperature front end: x1 term and set-up of the signed temperature divide
// two register stages; uses bsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsc_temp
    import bsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cal_t cal,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire pl_t  in_pl,
    output logic      out_valid,
    input  wire logic out_ready,
    output pl_t       out_pl
);

    logic [TEMP_STAGES-1:0] v_reg;
    logic [TEMP_STAGES:0]   adv;
    pl_t                    st_reg  [TEMP_STAGES];
    pl_t                    st_next [TEMP_STAGES];

    assign adv[TEMP_STAGES] = out_ready;
    assign in_ready         = adv[0];
    assign out_valid        = v_reg[TEMP_STAGES-1];
    assign out_pl           = st_reg[TEMP_STAGES-1];

    always_comb
    begin
        logic [31:0] x1;
        logic [31:0] den;
        logic [31:0] num;

        // (ut - ac6) * ac5
        st_next[0]    = in_pl;
        st_next[0].w0 = 32'((in_pl.w0 - cal.ac6) * cal.ac5);

        // magnitudes and sign for the truncating divide
        x1  = asr32(st_reg[0].w0, 5'd15);
        den = x1 + cal.md;
        num = cal.mc << 11;
        st_next[1]     = st_reg[0];
        st_next[1].w0  = num[31] ? 32'(-num) : num;
        st_next[1].w1  = den[31] ? 32'(-den) : den;
        st_next[1].w2  = x1;
        st_next[1].fl  = num[31] ^ den[31];
        st_next[1].err = (den == '0);
    end

    for (genvar k = 0; k < TEMP_STAGES; k++)
    begin : g_stage
        logic src_v;
        if (k == 0)
        begin : g_first
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src_v = v_reg[k-1];
        end

        assign adv[k] = !v_reg[k] || adv[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv[k])
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_v)
                st_reg[k] <= st_next[k];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bsc_pres.sv
// temperature finish and pressure terms b3, b4, b7 up to the pressure divide
// eight register stages; uses bsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsc_pres
    import bsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cal_t cal,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire pl_t  in_pl,
    output logic      out_valid,
    input  wire logic out_ready,
    output pl_t       out_pl
);

    logic [PRES_STAGES-1:0] v_reg;
    logic [PRES_STAGES:0]   adv;
    pl_t                    st_reg  [PRES_STAGES];
    pl_t                    st_next [PRES_STAGES];

    assign adv[PRES_STAGES] = out_ready;
    assign in_ready         = adv[0];
    assign out_valid        = v_reg[PRES_STAGES-1];
    assign out_pl           = st_reg[PRES_STAGES-1];

    always_comb
    begin
        logic [31:0] x2;
        logic [31:0] b5;
        logic [31:0] x1;
        logic [31:0] x3;
        logic [31:0] b3;
        logic [31:0] x3p;

        // b5, temperature and b6
        x2 = in_pl.fl ? 32'(-in_pl.w0) : in_pl.w0;
        b5 = in_pl.w2 + x2;
        st_next[0]      = in_pl;
        st_next[0].temp = sat_temp(asr32(b5 + TEMP_ROUND, 5'd4));
        st_next[0].w0   = b5 - B6_OFFSET;

        // b6 squared, ac2 * b6, ac3 * b6
        st_next[1]    = st_reg[0];
        st_next[1].w1 = 32'(st_reg[0].w0 * st_reg[0].w0);
        st_next[1].w2 = 32'(cal.ac2 * st_reg[0].w0);
        st_next[1].w3 = 32'(cal.ac3 * st_reg[0].w0);

        // sq, ac2 term, ac3 term
        st_next[2]    = st_reg[1];
        st_next[2].w0 = asr32(st_reg[1].w1, 5'd12);
        st_next[2].w1 = asr32(st_reg[1].w2, 5'd11);
        st_next[2].w2 = asr32(st_reg[1].w3, 5'd13);

        // b2 * sq and b1 * sq
        st_next[3]    = st_reg[2];
        st_next[3].w3 = 32'(cal.b2 * st_reg[2].w0);
        st_next[3].w0 = 32'(cal.b1 * st_reg[2].w0);

        // b3 and the b4 multiplicand
        x1  = asr32(st_reg[3].w3, 5'd11);
        x3  = x1 + st_reg[3].w1;
        b3  = asr32(((32'(cal.ac1 << 2) + x3) << cal.oss) + B3_ROUND, 5'd2);
        x3p = asr32(st_reg[3].w2 + asr32(st_reg[3].w0, 5'd16) + B3_ROUND, 5'd2);
        st_next[4]    = st_reg[3];
        st_next[4].w0 = b3;
        st_next[4].w1 = x3p + X3_BIAS;

        // ac4 product and up - b3
        st_next[5]    = st_reg[4];
        st_next[5].w2 = 32'(cal.ac4 * st_reg[4].w1);
        st_next[5].w0 = {13'd0, st_reg[4].up} - st_reg[4].w0;

        // b4 and b7
        st_next[6]    = st_reg[5];
        st_next[6].w1 = st_reg[5].w2 >> 15;
        st_next[6].w0 = 32'(st_reg[5].w0 * (PRES_SCALE >> cal.oss));

        // dividend: b7 doubled before the divide when it is small enough
        st_next[7]     = st_reg[6];
        st_next[7].err = st_reg[6].err || (st_reg[6].w1 == '0);
        st_next[7].fl  = st_reg[6].w0[31];
        st_next[7].w0  = st_reg[6].w0[31] ? st_reg[6].w0 : {st_reg[6].w0[30:0], 1'b0};
    end

    for (genvar k = 0; k < PRES_STAGES; k++)
    begin : g_stage
        logic src_v;
        if (k == 0)
        begin : g_first
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src_v = v_reg[k-1];
        end

        assign adv[k] = !v_reg[k] || adv[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv[k])
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_v)
                st_reg[k] <= st_next[k];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bsc_post.sv
// pressure correction polynomial, saturation and error zeroing
// four register stages, the last is the output register; uses bsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsc_post
    import bsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire pl_t  in_pl,
    output logic      out_valid,
    input  wire logic out_ready,
    output pl_t       out_pl
);

    logic [POST_STAGES-1:0] v_reg;
    logic [POST_STAGES:0]   adv;
    pl_t                    st_reg  [POST_STAGES];
    pl_t                    st_next [POST_STAGES];

    assign adv[POST_STAGES] = out_ready;
    assign in_ready         = adv[0];
    assign out_valid        = v_reg[POST_STAGES-1];
    assign out_pl           = st_reg[POST_STAGES-1];

    always_comb
    begin
        logic [31:0] p;
        logic [31:0] x1;
        logic [31:0] pr;

        // p
        p = in_pl.fl ? {in_pl.w0[30:0], 1'b0} : in_pl.w0;
        st_next[0]    = in_pl;
        st_next[0].w0 = p;
        st_next[0].w1 = asr32(p, 5'd8);

        st_next[1]    = st_reg[0];
        st_next[1].w1 = 32'(st_reg[0].w1 * st_reg[0].w1);
        st_next[1].w2 = 32'(LIN_COEF * st_reg[0].w0);

        st_next[2]    = st_reg[1];
        st_next[2].w1 = 32'(st_reg[1].w1 * SQ_COEF);
        st_next[2].w2 = asr32(st_reg[1].w2, 5'd16);

        x1 = asr32(st_reg[2].w1, 5'd16);
        pr = st_reg[2].w0 + asr32(x1 + st_reg[2].w2 + PRES_BIAS, 5'd4);
        st_next[3]    = st_reg[2];
        if (st_reg[2].err)
        begin
            st_next[3].temp = '0;
            st_next[3].w0   = '0;
        end
        else
        begin
            st_next[3].w0 = {14'd0, sat_pres(pr)};
        end
    end

    for (genvar k = 0; k < POST_STAGES; k++)
    begin : g_stage
        logic src_v;
        if (k == 0)
        begin : g_first
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src_v = v_reg[k-1];
        end

        assign adv[k] = !v_reg[k] || adv[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv[k])
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_v)
                st_reg[k] <= st_next[k];
        end
    end

endmodule

`default_nettype wire

// File: rtl/barometric_sensor_compensation_unit.sv
// top level of the barometric sensor compensation unit
// needs bsc_pkg, bsc_sample_if, bsc_result_if, bsc_temp, bsc_div, bsc_pres, bsc_post
`timescale 1ns / 1ps
`default_nettype none

// Compensates one raw temperature word and one raw pressure word per item with the
// factory calibration words and the oversampling setting held in the configuration
// registers, giving temperature in 0.1 degC and pressure in Pa, both saturated, and a
// divide_error flag (results forced to zero) when either divisor is zero. The unit takes
// one item every clock cycle unless a full pipe is held at the output; its depth comes mostly from the
// two 32-stage restoring dividers (signed temperature divide, unsigned pressure divide)
// that produce one quotient bit per stage. Every stage has its own valid bit and only
// stalls when the stage after it is full, so bubbles close up and the input stays ready,
// while a finished result waits at the output, as long as any stage holds a bubble.
// Write configuration only while no item is in flight.

module barometric_sensor_compensation_unit
    import bsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    bsc_sample_if.sink       sample,
    bsc_result_if.source     result
);

    // configuration registers
    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;
    cal_t        cal;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_CAL_A: cal_a_reg <= cfg_data;
                REG_CAL_B: cal_b_reg <= cfg_data;
                REG_CAL_C: cal_c_reg <= cfg_data[31:0];
                REG_OSS:   oss_reg   <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    // unpack coefficients: signed ones sign-extended, ac4..ac6 zero-extended
    always_comb
    begin
        cal.ac1 = sext16(cal_a_reg[15:0]);
        cal.ac2 = sext16(cal_a_reg[31:16]);
        cal.ac3 = sext16(cal_a_reg[47:32]);
        cal.ac4 = {16'd0, cal_a_reg[63:48]};
        cal.ac5 = {16'd0, cal_b_reg[15:0]};
        cal.ac6 = {16'd0, cal_b_reg[31:16]};
        cal.b1  = sext16(cal_b_reg[47:32]);
        cal.b2  = sext16(cal_b_reg[63:48]);
        cal.mc  = sext16(cal_c_reg[15:0]);
        cal.md  = sext16(cal_c_reg[31:16]);
        cal.oss = oss_reg;
    end

    // input item into the pipe payload
    pl_t in_pl;
    always_comb
    begin
        in_pl    = '0;
        in_pl.up = sample.raw_pressure;
        in_pl.w0 = {16'd0, sample.raw_temperature};
    end

    // pipe links
    logic t_valid,  t_ready;
    logic d1_valid, d1_ready;
    logic p_valid,  p_ready;
    logic d2_valid, d2_ready;
    pl_t  t_pl, d1_pl, p_pl, d2_pl, o_pl;

    // x1 and divide set-up
    bsc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .in_pl     (in_pl),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_pl    (t_pl)
    );

    // temperature divide: (mc << 11) / (x1 + md) on magnitudes
    bsc_div u_div_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_pl     (t_pl),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_pl    (d1_pl)
    );

    // temperature result and pressure terms
    bsc_pres u_pres (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_pl     (d1_pl),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_pl    (p_pl)
    );

    // pressure divide by b4
    bsc_div u_div_pres (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_pl     (p_pl),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .out_pl    (d2_pl)
    );

    // correction polynomial and output register
    bsc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_valid),
        .in_ready  (d2_ready),
        .in_pl     (d2_pl),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_pl    (o_pl)
    );

    assign result.temperature_tenths = o_pl.temp;
    assign result.pressure_pa        = o_pl.w0[17:0];
    assign result.divide_error       = o_pl.err;

    // an empty output register means every stage can move, so input must be ready
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> sample.ready)
        else $error("input not ready although output stage is empty");

    // a divide error item carries zero results
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.divide_error |->
            result.temperature_tenths == 16'sd0 && result.pressure_pa == 18'd0)
        else $error("divide error item with nonzero results");

    // oversampling write lands in the register
    a_oss_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_OSS |=> oss_reg == $past(cfg_data[1:0]))
        else $error("oversampling write lost");

endmodule

`default_nettype wire
